// ----- rtl/core/ohh_pkg.sv -----
// Package: sizes, opcodes, class codes and controller/datapath structs for the hit histogram.
package ohh_pkg;
  localparam int NUM_ENTRIES = 1024;
  localparam int ADDR_W      = $clog2(NUM_ENTRIES);
  localparam int KEY_W       = 10;
  localparam int CNT_W       = 64;
  localparam int RANK_W      = 7;
  localparam int MAX_REPORT  = 64;

  localparam logic [1:0] OP_COUNT  = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_CLASS  = 2'd2;
  localparam logic [1:0] OP_REPORT = 2'd3;

  localparam logic [2:0] SEL_ALL = 3'd0;
  localparam logic [2:0] SEL_ALU = 3'd1;
  localparam logic [2:0] SEL_FPU = 3'd2;
  localparam logic [2:0] SEL_VEC = 3'd3;
  localparam logic [2:0] SEL_LS  = 3'd4;

  typedef struct packed {
    logic load;
    logic addr_clr;
    logic addr_inc;
    logic init_wr;
    logic clr_wr;
    logic cnt_rd;
    logic cnt_wr;
    logic flg_wr;
    logic scan_rd;
    logic pick_mode;
    logic pick_clr;
    logic emit;
    logic emit_none;
  } ohh_cmd_t;

  typedef struct packed {
    logic addr_last;
    logic total_zero;
    logic limit_zero;
    logic pick_done;
    logic out_busy;
  } ohh_stat_t;

  function automatic logic sel_hit(input logic [3:0] flags, input logic [2:0] sel);
    logic r;
    case (sel)
      SEL_ALL: r = 1'b1;
      SEL_ALU: r = flags[0];
      SEL_FPU: r = flags[1];
      SEL_VEC: r = flags[2];
      SEL_LS:  r = flags[3];
      default: r = 1'b0;
    endcase
    return r;
  endfunction
endpackage

// ----- rtl/core/ohh_ifs.sv -----
// Interfaces: request channel and result channel of the hit histogram.
interface ohh_in_if;
  import ohh_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [KEY_W-1:0]  entry_key;
  logic [3:0]        class_bits;
  logic [2:0]        class_select;
  logic [RANK_W-1:0] top_count;
  modport source (output valid, opcode, entry_key, class_bits, class_select, top_count,
                  input ready);
  modport sink (input valid, opcode, entry_key, class_bits, class_select, top_count,
                output ready);
endinterface

interface ohh_out_if;
  import ohh_pkg::*;
  logic              valid;
  logic              ready;
  logic [RANK_W-1:0] rank;
  logic [KEY_W-1:0]  result_key;
  logic [CNT_W-1:0]  hit_count;
  logic              no_counts;
  logic              last;
  modport source (output valid, rank, result_key, hit_count, no_counts, last, input ready);
  modport sink (input valid, rank, result_key, hit_count, no_counts, last, output ready);
endinterface

// ----- rtl/core/opcode_hit_histogram_top_k_top.sv -----
// Top level: hit-count histogram with top-K report.
//   channel | dir | payload
//   in_ch   | in  | opcode, entry_key, class_bits, class_select, top_count
//   out_ch  | out | rank, result_key, hit_count, no_counts, last
// After reset a pass over all 1024 entries zeroes counters and class flags; no request is taken meanwhile.
// Count: read, write, back to idle; class write: write, back to idle; clear: one pass over all entries.
// Report: one 1024-entry scan to count qualifying entries, then one 1024-entry scan
// per reported entry, through the single read port of the counter memory.
// Reset is synchronous, active low; a stalled result holds the next emit, not the scans.
module opcode_hit_histogram_top_k_top import ohh_pkg::*; (
  input logic   clk,
  input logic   rst_n,
  ohh_in_if.sink    in_ch,
  ohh_out_if.source out_ch
);
  ohh_cmd_t  cmd;
  ohh_stat_t st;

  ohh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_opcode (in_ch.opcode),
    .st        (st),
    .cmd       (cmd)
  );

  ohh_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_key    (in_ch.entry_key),
    .in_bits   (in_ch.class_bits),
    .in_sel    (in_ch.class_select),
    .in_top    (in_ch.top_count),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_rank  (out_ch.rank),
    .out_key   (out_ch.result_key),
    .out_count (out_ch.hit_count),
    .out_none  (out_ch.no_counts),
    .out_last  (out_ch.last)
  );
endmodule

// ----- rtl/core/ohh_datapath.sv -----
// Datapath: counter and class memories, table scan, top-entry selection, result register.
module ohh_datapath import ohh_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  ohh_cmd_t          cmd,
  output ohh_stat_t         st,
  input  logic [KEY_W-1:0]  in_key,
  input  logic [3:0]        in_bits,
  input  logic [2:0]        in_sel,
  input  logic [RANK_W-1:0] in_top,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [RANK_W-1:0] out_rank,
  output logic [KEY_W-1:0]  out_key,
  output logic [CNT_W-1:0]  out_count,
  output logic              out_none,
  output logic              out_last
);
  logic [CNT_W-1:0]  cnt_mem [NUM_ENTRIES];
  logic [3:0]        flg_mem [NUM_ENTRIES];

  logic [KEY_W-1:0]  key_r;
  logic [3:0]        bits_r;
  logic [2:0]        sel_r;
  logic [RANK_W-1:0] want_r;
  logic [ADDR_W-1:0] addr_r;
  logic [CNT_W-1:0]  rd_cnt_r;
  logic [3:0]        rd_flg_r;
  logic              v1_r;
  logic [ADDR_W-1:0] key1_r;
  logic [RANK_W-1:0] total_r;
  logic [RANK_W-1:0] n_r;
  logic              found_r;
  logic [CNT_W-1:0]  best_cnt_r;
  logic [ADDR_W-1:0] best_key_r;
  logic [CNT_W-1:0]  prev_cnt_r;
  logic [ADDR_W-1:0] prev_key_r;
  logic              out_valid_r;
  logic [RANK_W-1:0] out_rank_r;
  logic [KEY_W-1:0]  out_key_r;
  logic [CNT_W-1:0]  out_count_r;
  logic              out_none_r;
  logic              out_last_r;

  logic              key_ok;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic              qual;
  logic              below;
  logic              take;
  logic [RANK_W-1:0] eff_limit;
  logic [RANK_W-1:0] n_inc;

  assign key_ok    = ({1'b0, key_r} < (KEY_W+1)'(NUM_ENTRIES));
  assign rd_addr   = cmd.cnt_rd ? key_r[ADDR_W-1:0] : addr_r;
  assign wr_addr   = (cmd.cnt_wr || cmd.flg_wr) ? key_r[ADDR_W-1:0] : addr_r;
  assign qual      = v1_r && (rd_cnt_r != '0) && sel_hit(rd_flg_r, sel_r);
  assign below     = (n_r == '0) || (rd_cnt_r < prev_cnt_r) ||
                     ((rd_cnt_r == prev_cnt_r) && (key1_r > prev_key_r));
  assign take      = qual && below && (!found_r || (rd_cnt_r > best_cnt_r));
  assign eff_limit = (want_r < total_r) ? want_r : total_r;
  assign n_inc     = n_r + RANK_W'(1);

  assign st.addr_last  = (addr_r == ADDR_W'(NUM_ENTRIES - 1));
  assign st.total_zero = (total_r == '0);
  assign st.limit_zero = (eff_limit == '0);
  assign st.pick_done  = (n_r == eff_limit);
  assign st.out_busy   = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.init_wr || cmd.clr_wr || (cmd.cnt_wr && key_ok)) begin
      cnt_mem[wr_addr] <= cmd.cnt_wr ? rd_cnt_r + CNT_W'(1) : '0;
    end
    if (cmd.init_wr || (cmd.flg_wr && key_ok)) begin
      flg_mem[wr_addr] <= cmd.flg_wr ? bits_r : 4'd0;
    end
    if (cmd.cnt_rd || cmd.scan_rd) begin
      rd_cnt_r <= cnt_mem[rd_addr];
      rd_flg_r <= flg_mem[rd_addr];
    end
    key1_r <= addr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r      <= '0;
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      n_r         <= '0;
      total_r     <= '0;
    end else begin
      v1_r <= cmd.scan_rd;
      if (cmd.addr_clr) begin
        addr_r <= '0;
      end else if (cmd.addr_inc) begin
        addr_r <= addr_r + ADDR_W'(1);
      end
      if (cmd.load) begin
        n_r     <= '0;
        total_r <= '0;
      end else if (!cmd.pick_mode && qual && (total_r != RANK_W'(MAX_REPORT))) begin
        total_r <= total_r + RANK_W'(1);
      end
      if (cmd.pick_clr) begin
        found_r <= 1'b0;
      end else if (cmd.pick_mode && take) begin
        found_r <= 1'b1;
      end
      if (cmd.emit) begin
        n_r <= n_inc;
      end
      if (cmd.emit || cmd.emit_none) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r  <= in_key;
      bits_r <= in_bits;
      sel_r  <= in_sel;
      want_r <= (in_top > RANK_W'(MAX_REPORT)) ? RANK_W'(MAX_REPORT) : in_top;
    end
    if (cmd.pick_mode && take) begin
      best_cnt_r <= rd_cnt_r;
      best_key_r <= key1_r;
    end
    if (cmd.emit) begin
      prev_cnt_r  <= best_cnt_r;
      prev_key_r  <= best_key_r;
      out_rank_r  <= n_inc;
      out_key_r   <= KEY_W'(best_key_r);
      out_count_r <= best_cnt_r;
      out_none_r  <= 1'b0;
      out_last_r  <= (n_inc == eff_limit);
    end else if (cmd.emit_none) begin
      out_rank_r  <= '0;
      out_key_r   <= '0;
      out_count_r <= '0;
      out_none_r  <= 1'b1;
      out_last_r  <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rank  = out_rank_r;
  assign out_key   = out_key_r;
  assign out_count = out_count_r;
  assign out_none  = out_none_r;
  assign out_last  = out_last_r;

  ap_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit || cmd.emit_none) |-> !st.out_busy) else $error("result overwritten");
  ap_emit_found: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> found_r) else $error("emit without a selected entry");
  ap_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (n_r < RANK_W'(MAX_REPORT))) else $error("rank beyond cap");
endmodule

// ----- rtl/core/ohh_ctrl.sv -----
// Controller: sequences clearing passes, counter and class updates and report scans.
module ohh_ctrl import ohh_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic [1:0] in_opcode,
  input  ohh_stat_t st,
  output ohh_cmd_t  cmd
);
  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_RD     = 4'd2;
  localparam logic [3:0] S_WR     = 4'd3;
  localparam logic [3:0] S_FLAG   = 4'd4;
  localparam logic [3:0] S_CLR    = 4'd5;
  localparam logic [3:0] S_TOT    = 4'd6;
  localparam logic [3:0] S_TDRAIN = 4'd7;
  localparam logic [3:0] S_TCHK   = 4'd8;
  localparam logic [3:0] S_NONE   = 4'd9;
  localparam logic [3:0] S_PICK   = 4'd10;
  localparam logic [3:0] S_PDRAIN = 4'd11;
  localparam logic [3:0] S_EMIT   = 4'd12;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_INIT: begin
        cmd.init_wr  = 1'b1;
        cmd.addr_inc = 1'b1;
        if (st.addr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        cmd.addr_clr = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          case (in_opcode)
            OP_COUNT: state_nxt = S_RD;
            OP_CLEAR: state_nxt = S_CLR;
            OP_CLASS: state_nxt = S_FLAG;
            default:  state_nxt = S_TOT;
          endcase
        end
      end
      S_RD: begin
        cmd.cnt_rd = 1'b1;
        state_nxt  = S_WR;
      end
      S_WR: begin
        cmd.cnt_wr = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_FLAG: begin
        cmd.flg_wr = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_CLR: begin
        cmd.clr_wr   = 1'b1;
        cmd.addr_inc = 1'b1;
        if (st.addr_last) state_nxt = S_IDLE;
      end
      S_TOT: begin
        cmd.scan_rd  = 1'b1;
        cmd.addr_inc = 1'b1;
        if (st.addr_last) state_nxt = S_TDRAIN;
      end
      S_TDRAIN: state_nxt = S_TCHK;
      S_TCHK: begin
        cmd.addr_clr = 1'b1;
        cmd.pick_clr = 1'b1;
        if (st.total_zero) state_nxt = S_NONE;
        else if (st.limit_zero) state_nxt = S_IDLE;
        else state_nxt = S_PICK;
      end
      S_NONE: begin
        if (!st.out_busy) begin
          cmd.emit_none = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_PICK: begin
        cmd.pick_mode = 1'b1;
        cmd.scan_rd   = 1'b1;
        cmd.addr_inc  = 1'b1;
        if (st.addr_last) state_nxt = S_PDRAIN;
      end
      S_PDRAIN: begin
        cmd.pick_mode = 1'b1;
        state_nxt     = S_EMIT;
      end
      S_EMIT: begin
        cmd.pick_mode = 1'b1;
        if (!st.out_busy) begin
          cmd.emit = 1'b1;
          state_nxt = S_TCHK;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (state_r == S_TCHK && !st.total_zero && st.pick_done) begin
      state_nxt = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  ap_rmw: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |=> (state_r == S_WR)) else $error("counter update split");
  ap_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !cmd.scan_rd && !cmd.clr_wr && !cmd.init_wr) else $error("ready while busy");
  ap_init: assert property (@(posedge clk)
    !rst_n |=> (state_r == S_INIT)) else $error("reset skipped clearing pass");
endmodule
